// ===== rtl/core/dh_link_transform_macros.svh =====
// ---------------------------------------------------------------------------
// dh link transform assertion macros
// wrappers for concurrent checks, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef DH_LINK_TRANSFORM_MACROS_SVH
`define DH_LINK_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
`define DH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DH_ASSERT_IMP(label, clk, rst, ante, cons)
`define DH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/dhlt_pkg.sv =====
// ---------------------------------------------------------------------------
// dhlt package
// fixed-point constants and the cordic arctangent table
// ---------------------------------------------------------------------------
package dhlt_pkg;
  localparam int Steps = 16;
  localparam int ZW = 20;
  localparam int XW = 32;
  localparam logic signed [ZW-1:0] PiQ16 = 20'sd205887;
  localparam logic signed [ZW-1:0] TwoPiQ16 = 20'sd411775;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [XW-1:0] GainQ28 = 32'sd163008219;
  localparam logic signed [15:0] TrigMax = 16'sd16384;
  localparam logic signed [15:0] TrigMin = -16'sd16384;

  typedef enum logic [0:0] {
    REG_LINK_LENGTH = 1'b0,
    REG_LINK_TWIST  = 1'b1
  } reg_index_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0: r = 20'sd51472;
      4'd1: r = 20'sd30386;
      4'd2: r = 20'sd16055;
      4'd3: r = 20'sd8150;
      4'd4: r = 20'sd4091;
      4'd5: r = 20'sd2047;
      4'd6: r = 20'sd1024;
      4'd7: r = 20'sd512;
      4'd8: r = 20'sd256;
      4'd9: r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  // round a q28 value to q14 and clamp to the unit range
  function automatic logic signed [15:0] round_trig(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    logic signed [XW-15:0] q;
    s = v + 32'sd8192;
    q = s[XW-1:14];
    if (q > 18'sd16384) return TrigMax;
    if (q < -18'sd16384) return TrigMin;
    return q[15:0];
  endfunction
endpackage

// ===== rtl/core/dhlt_cordic.sv =====
// ---------------------------------------------------------------------------
// dhlt cordic
// pipelined sine and cosine, range reduction then one rotation per stage
// ---------------------------------------------------------------------------
`include "dh_link_transform_macros.svh"
module dhlt_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [15:0]  angle,
  output logic                out_valid,
  output logic signed [15:0]  cos_q14,
  output logic signed [15:0]  sin_q14
);
  import dhlt_pkg::*;

  logic                 vld  [Steps+2];
  logic signed [XW-1:0] xs   [Steps+1];
  logic signed [XW-1:0] ys   [Steps+1];
  logic signed [ZW-1:0] zs   [Steps+1];
  logic                 flip [Steps+1];
  logic signed [ZW-1:0] z0, z1, z2;
  logic                 f0;

  always_comb begin
    z0 = {angle, 4'b0};
    z1 = z0;
    if (z0 > PiQ16) z1 = z0 - TwoPiQ16;
    else if (z0 < -PiQ16) z1 = z0 + TwoPiQ16;
    z2 = z1;
    f0 = 1'b0;
    if (z1 > HalfPiQ16) begin
      z2 = z1 - PiQ16;
      f0 = 1'b1;
    end else if (z1 < -HalfPiQ16) begin
      z2 = z1 + PiQ16;
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Steps + 2; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < Steps + 2; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= GainQ28;
    ys[0] <= '0;
    zs[0] <= z2;
    flip[0] <= f0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q16(4'(i));
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q16(4'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    cos_q14 <= round_trig(flip[Steps] ? -xs[Steps] : xs[Steps]);
    sin_q14 <= round_trig(flip[Steps] ? -ys[Steps] : ys[Steps]);
  end

  assign out_valid = vld[Steps+1];

  `DH_ASSERT_IMP(a_cos_range, clk, rst, out_valid, cos_q14 <= TrigMax && cos_q14 >= TrigMin)
  `DH_ASSERT_IMP(a_sin_range, clk, rst, out_valid, sin_q14 <= TrigMax && sin_q14 >= TrigMin)
  `DH_ASSERT_NEXT(a_valid_flow, clk, rst, vld[Steps], out_valid)
endmodule

// ===== rtl/core/dh_link_transform.sv =====
// ---------------------------------------------------------------------------
// dh link transform
// standard denavit-hartenberg matrix of one link, fully pipelined
// ---------------------------------------------------------------------------
// One item enters per clock on start; busy is never raised. Each result
// appears on done for one cycle, after the 16-stage cordic with its
// reduction and rounding registers, a product stage and an output stage.
// The receiver cannot stall, so no backpressure exists. link_length and
// link_twist should be written only when no item is in flight.
`include "dh_link_transform_macros.svh"
module dh_link_transform (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  joint_angle,
  input  logic signed [31:0]  joint_offset,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output logic signed [15:0]  r11,
  output logic signed [15:0]  r12,
  output logic signed [15:0]  r13,
  output logic signed [31:0]  pos_x,
  output logic signed [15:0]  r21,
  output logic signed [15:0]  r22,
  output logic signed [15:0]  r23,
  output logic signed [31:0]  pos_y,
  output logic signed [15:0]  r32,
  output logic signed [15:0]  r33,
  output logic signed [31:0]  pos_z
);
  import dhlt_pkg::*;

  localparam int Lat = Steps + 2;

  logic signed [31:0] link_length;
  logic signed [15:0] link_twist;
  logic               acc;
  logic               tv, av;
  logic signed [15:0] ct, st, ca, sa;
  logic signed [31:0] d_pipe [Lat];
  logic               v1;
  logic signed [31:0] p_sc, p_ss, p_cc, p_cs;
  logic signed [47:0] p_ac, p_as;
  logic signed [15:0] ct1, st1, ca1, sa1;
  logic signed [31:0] d1;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_length <= '0;
      link_twist <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_LINK_LENGTH: link_length <= cfg_data;
        REG_LINK_TWIST:  link_twist <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dhlt_cordic u_theta (.clk, .rst, .in_valid(acc), .angle(joint_angle),
    .out_valid(tv), .cos_q14(ct), .sin_q14(st));
  dhlt_cordic u_alpha (.clk, .rst, .in_valid(acc), .angle(link_twist),
    .out_valid(av), .cos_q14(ca), .sin_q14(sa));

  always_ff @(posedge clk) begin
    d_pipe[0] <= joint_offset;
    for (int k = 1; k < Lat; k++) d_pipe[k] <= d_pipe[k-1];
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= tv;
    p_sc <= st * ca;
    p_ss <= st * sa;
    p_cc <= ct * ca;
    p_cs <= ct * sa;
    p_ac <= 48'(link_length) * 48'(ct);
    p_as <= 48'(link_length) * 48'(st);
    ct1 <= ct; st1 <= st; ca1 <= ca; sa1 <= sa;
    d1 <= d_pipe[Lat-1];
  end

  function automatic logic signed [15:0] rnd14(input logic signed [31:0] p);
    logic signed [31:0] s;
    s = p + 32'sd8192;
    return s[29:14];
  endfunction

  function automatic logic signed [31:0] rndpos(input logic signed [47:0] p);
    logic signed [47:0] s;
    logic signed [33:0] q;
    s = p + 48'sd8192;
    q = s[47:14];
    if (q > 34'sd2147483647) return 32'h7fffffff;
    return q[31:0];
  endfunction

  // output stage
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v1;
    r11 <= ct1;
    r12 <= -rnd14(p_sc);
    r13 <= rnd14(p_ss);
    pos_x <= rndpos(p_ac);
    r21 <= st1;
    r22 <= rnd14(p_cc);
    r23 <= -rnd14(p_cs);
    pos_y <= rndpos(p_as);
    r32 <= sa1;
    r33 <= ca1;
    pos_z <= d1;
  end

  `DH_ASSERT_IMP(a_lanes_aligned, clk, rst, 1'b1, tv == av)
  `DH_ASSERT_NEXT(a_done_follows, clk, rst, v1, done)
  `DH_ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy && cfg_ready)
endmodule
